[rtl/core/rgbconv_pkg.sv]
`timescale 1ns / 1ps

package rgbconv_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int TAP_W      = 18;
    localparam int ROW_COEF_W = 3 * TAP_W;
    localparam int FRAC_BITS  = 10;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = CHAN_W + 1 + TAP_W;
    localparam int ACC_W      = PROD_W + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT     = 3'd4;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pix_t;

endpackage

[rtl/core/rgbconv_in_if.sv]
`timescale 1ns / 1ps

interface rgbconv_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    rgbconv_pkg::chan_t   in_blue;
    rgbconv_pkg::chan_t   in_green;
    rgbconv_pkg::chan_t   in_red;

    modport source (output valid, output mode, output in_blue, output in_green,
                    output in_red, input ready);
    modport sink (input valid, input mode, input in_blue, input in_green,
                  input in_red, output ready);
endinterface

[rtl/core/rgbconv_out_if.sv]
`timescale 1ns / 1ps

interface rgbconv_out_if;
    logic                 valid;
    logic                 ready;
    rgbconv_pkg::chan_t   out_blue;
    rgbconv_pkg::chan_t   out_green;
    rgbconv_pkg::chan_t   out_red;
    logic                 last_of_frame;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output last_of_frame, input ready);
    modport sink (input valid, input out_blue, input out_green, input out_red,
                  input last_of_frame, output ready);
endinterface

[rtl/core/rgb_2d_convolution_zero_pad_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Carries
// in_ch     sink       mode, in_blue, in_green, in_red
// out_ch    source     out_blue, out_green, out_red, last_of_frame
// cfg       write      cfg_write_en, cfg_index, cfg_data
//
// One input transfer is accepted every cycle while the output register is free or being
// emptied; the result of a transfer appears once it has passed the stage registers below.
// The pipeline runs line-store read, window update, multiply and sum-round stages.
// Reset clears the counters, the window and the stage valid bits; the line store is not
// cleared. A stalled output holds the whole pipeline, and in_ch.ready drops with it.

module rgb_2d_convolution_zero_pad_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    rgbconv_in_if.sink                                in_ch,
    rgbconv_out_if.source                             out_ch,
    input  logic                                      cfg_write_en,
    input  logic [rgbconv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rgbconv_pkg::ROW_COEF_W-1:0]        cfg_data
);

    localparam int CW = rgbconv_pkg::CHAN_W;
    localparam int TW = rgbconv_pkg::TAP_W;

    logic [rgbconv_pkg::WIDTH_W-1:0]    width_reg;
    logic [rgbconv_pkg::HEIGHT_W-1:0]   height_reg;
    logic [rgbconv_pkg::ROW_COEF_W-1:0] coef_reg [3];

    logic [rgbconv_pkg::COL_W-1:0] in_col_reg, in_col_next;
    logic [rgbconv_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [rgbconv_pkg::COL_W-1:0] out_col_reg, out_col_next;
    logic [rgbconv_pkg::ROW_W-1:0] out_row_reg, out_row_next;

    logic [rgbconv_pkg::WIDTH_W-1:0]  w_eff;
    logic [rgbconv_pkg::HEIGHT_W-1:0] h_eff;
    logic [rgbconv_pkg::WIDTH_W-1:0]  col_inc, ocol_inc;
    logic [rgbconv_pkg::ROW_W-1:0]    row_inc, orow_inc;
    logic                             emit0, row_end0, last0, accept, en;
    rgbconv_pkg::pix_t                pix0;

    rgbconv_pkg::pix_t top_mem [rgbconv_pkg::MAX_WIDTH];
    rgbconv_pkg::pix_t mid_mem [rgbconv_pkg::MAX_WIDTH];
    rgbconv_pkg::pix_t top_q_reg, mid_q_reg, byp_top_reg, byp_mid_reg;
    logic              byp_reg;

    logic                          v1_reg, emit1_reg, rowge1_reg, rowge2_reg, early1_reg;
    logic                          lzero1_reg, rend1_reg, last1_reg;
    logic [rgbconv_pkg::COL_W-1:0] col1_reg;
    rgbconv_pkg::pix_t             pix1_reg;
    rgbconv_pkg::pix_t             top1, mid1;
    rgbconv_pkg::pix_t             win_reg [3][3];
    rgbconv_pkg::pix_t             taps1 [3][3];

    logic                          v2_reg, last2_reg;
    rgbconv_pkg::pix_t             taps2_reg [3][3];

    logic                          v3_reg, last3_reg;
    logic signed [rgbconv_pkg::PROD_W-1:0] prod_reg [3][3][3];

    logic                          out_valid_reg, out_last_reg;
    rgbconv_pkg::chan_t            out_pix_reg [3];

    function automatic rgbconv_pkg::chan_t round_clamp(
        input logic signed [rgbconv_pkg::ACC_W-1:0] acc);
        logic [rgbconv_pkg::ACC_W-rgbconv_pkg::FRAC_BITS-1:0] q;
        logic [rgbconv_pkg::FRAC_BITS-1:0]                    rem;
        logic [rgbconv_pkg::FRAC_BITS-1:0]                    half;
        logic                                                 up;
        q    = acc[rgbconv_pkg::ACC_W-1:rgbconv_pkg::FRAC_BITS];
        rem  = acc[rgbconv_pkg::FRAC_BITS-1:0];
        half = {1'b1, {(rgbconv_pkg::FRAC_BITS-1){1'b0}}};
        up   = (rem > half) || (rem == half && q[0]);
        q    = q + {{(rgbconv_pkg::ACC_W-rgbconv_pkg::FRAC_BITS-1){1'b0}}, up};
        if (acc <= 0)
        begin
            return '0;
        end
        else if (q > 255)
        begin
            return '1;
        end
        return q[CW-1:0];
    endfunction

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;
    assign accept      = en && in_ch.valid;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 11'd1;
        else if (width_reg > 11'(rgbconv_pkg::MAX_WIDTH))
            w_eff = 11'(rgbconv_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (height_reg > 13'(rgbconv_pkg::MAX_HEIGHT))
            h_eff = 13'(rgbconv_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;

        col_inc  = {1'b0, in_col_reg} + 11'd1;
        row_inc  = in_row_reg + 13'd1;
        ocol_inc = {1'b0, out_col_reg} + 11'd1;
        orow_inc = out_row_reg + 13'd1;
        emit0    = (in_row_reg >= 13'd2) || (in_row_reg == 13'd1 && in_col_reg != '0);
        row_end0 = ocol_inc >= w_eff;
        last0    = row_end0 && (orow_inc >= h_eff);

        if (!in_ch.mode && in_row_reg < h_eff)
            pix0 = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
        else
            pix0 = '0;

        if (col_inc >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = row_inc;
        end
        else
        begin
            in_col_next = col_inc[rgbconv_pkg::COL_W-1:0];
            in_row_next = in_row_reg;
        end
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit0)
        begin
            if (last0)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (row_end0)
            begin
                out_col_next = '0;
                out_row_next = orow_inc;
            end
            else
            begin
                out_col_next = ocol_inc[rgbconv_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 11'd640;
            height_reg  <= 13'd480;
            coef_reg[0] <= '0;
            coef_reg[1] <= 54'd262144;
            coef_reg[2] <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rgbconv_pkg::CFG_IMAGE_WIDTH:  width_reg   <= cfg_data[rgbconv_pkg::WIDTH_W-1:0];
                rgbconv_pkg::CFG_IMAGE_HEIGHT: height_reg  <= cfg_data[rgbconv_pkg::HEIGHT_W-1:0];
                rgbconv_pkg::CFG_COEF_TOP:     coef_reg[0] <= cfg_data;
                rgbconv_pkg::CFG_COEF_MID:     coef_reg[1] <= cfg_data;
                rgbconv_pkg::CFG_COEF_BOT:     coef_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_comb
    begin
        top1 = rowge2_reg ? (byp_reg ? byp_top_reg : top_q_reg) : '0;
        mid1 = rowge1_reg ? (byp_reg ? byp_mid_reg : mid_q_reg) : '0;
        for (int r = 0; r < 3; r++)
        begin
            if (early1_reg)
            begin
                taps1[r][0] = win_reg[r][1];
                taps1[r][1] = win_reg[r][2];
                taps1[r][2] = '0;
            end
            else
            begin
                taps1[r][0] = win_reg[r][1];
                taps1[r][1] = win_reg[r][2];
                taps1[r][2] = (r == 0) ? top1 : (r == 1) ? mid1 : pix1_reg;
            end
            if (lzero1_reg)
                taps1[r][0] = '0;
            if (rend1_reg)
                taps1[r][2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_q_reg   <= top_mem[in_col_reg];
            mid_q_reg   <= mid_mem[in_col_reg];
            byp_reg     <= v1_reg && (col1_reg == in_col_reg);
            byp_top_reg <= mid1;
            byp_mid_reg <= pix1_reg;
            if (v1_reg)
            begin
                top_mem[col1_reg] <= mid1;
                mid_mem[col1_reg] <= pix1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (en)
        begin
            v1_reg        <= in_ch.valid;
            v2_reg        <= v1_reg && emit1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
            if (v1_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= top1;
                win_reg[1][2] <= mid1;
                win_reg[2][2] <= pix1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix1_reg   <= pix0;
            col1_reg   <= in_col_reg;
            emit1_reg  <= emit0;
            rowge1_reg <= in_row_reg >= 13'd1;
            rowge2_reg <= in_row_reg >= 13'd2;
            early1_reg <= in_col_reg == '0;
            lzero1_reg <= out_col_reg == '0;
            rend1_reg  <= row_end0;
            last1_reg  <= last0;

            last2_reg  <= last1_reg;
            taps2_reg  <= taps1;

            last3_reg  <= last2_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        prod_reg[ch][r][c] <=
                            $signed({1'b0, taps2_reg[r][c][ch*CW +: CW]}) *
                            $signed(coef_reg[r][c*TW +: TW]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [rgbconv_pkg::ACC_W-1:0] acc;
        if (en)
        begin
            out_last_reg <= last3_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                acc = '0;
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        acc = acc + rgbconv_pkg::ACC_W'(prod_reg[ch][r][c]);
                    end
                end
                out_pix_reg[ch] <= round_clamp(acc);
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_blue      = out_pix_reg[0];
    assign out_ch.out_green     = out_pix_reg[1];
    assign out_ch.out_red       = out_pix_reg[2];
    assign out_ch.last_of_frame = out_last_reg;

endmodule

[tb/rgb_2d_convolution_zero_pad_top_test.sv]
`timescale 1ns / 1ps

module rgb_2d_convolution_zero_pad_top_test;

    typedef struct packed {
        logic [rgbconv_pkg::CHAN_W-1:0] blue;
        logic [rgbconv_pkg::CHAN_W-1:0] green;
        logic [rgbconv_pkg::CHAN_W-1:0] red;
        logic                           last;
    } out_pixel_t;

    typedef rgbconv_pkg::pix_t window_t [0:2][0:2];

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [rgbconv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rgbconv_pkg::ROW_COEF_W-1:0] cfg_data;

    rgbconv_in_if  in_ch ();
    rgbconv_out_if out_ch ();

    rgb_2d_convolution_zero_pad_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rgbconv_pkg::pix_t                  line_mem [0:2*rgbconv_pkg::MAX_WIDTH-1];
    window_t                            win;
    int unsigned                        in_col, in_row, out_col, out_row;
    logic [rgbconv_pkg::WIDTH_W-1:0]    img_width;
    logic [rgbconv_pkg::HEIGHT_W-1:0]   img_height;
    logic [rgbconv_pkg::ROW_COEF_W-1:0] kernel_rows [0:2];

    out_pixel_t  pending_pixels [$];
    int          error_count;
    int          pixels_checked;
    int          frames_sent;
    int          items_sent;
    int          burst_left;
    int unsigned cycle_count = 0;
    int          stall_style = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(img_width);
        if (w == 0) w = 1;
        if (w > rgbconv_pkg::MAX_WIDTH) w = rgbconv_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = 32'(img_height);
        if (h == 0) h = 1;
        if (h > rgbconv_pkg::MAX_HEIGHT) h = rgbconv_pkg::MAX_HEIGHT;
        return h;
    endfunction

    function automatic logic [rgbconv_pkg::CHAN_W-1:0] filter_channel(window_t t, int ch);
        longint acc;
        longint pv;
        longint cv;
        longint q;
        longint rem;
        logic signed [rgbconv_pkg::TAP_W-1:0] coef;
        acc = 0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef = kernel_rows[r][rgbconv_pkg::TAP_W*c +: rgbconv_pkg::TAP_W];
                cv = longint'(coef);
                pv = longint'(t[r][c][rgbconv_pkg::CHAN_W*ch +: rgbconv_pkg::CHAN_W]);
                acc += pv * cv;
            end
        end
        if (acc <= 0) return '0;
        q = acc >>> rgbconv_pkg::FRAC_BITS;
        rem = acc & ((1 << rgbconv_pkg::FRAC_BITS) - 1);
        if (rem > (1 << (rgbconv_pkg::FRAC_BITS - 1)) ||
            (rem == (1 << (rgbconv_pkg::FRAC_BITS - 1)) && q[0]))
            q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Advances the convolution state by one accepted input transfer.
    task automatic convolve_transfer(logic m, rgbconv_pkg::chan_t b, rgbconv_pkg::chan_t g,
                                     rgbconv_pkg::chan_t r);
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        rgbconv_pkg::pix_t pix;
        rgbconv_pkg::pix_t top;
        rgbconv_pkg::pix_t mid;
        logic              emit;
        logic              early;
        logic              row_end;
        logic              last;
        window_t           t;
        out_pixel_t        res;
        w = active_width();
        h = active_height();
        col = (in_col < rgbconv_pkg::MAX_WIDTH) ? in_col : rgbconv_pkg::MAX_WIDTH - 1;
        pix = '0;
        if (!m && in_row < h) pix = {r, g, b};
        top = (in_row >= 2) ? line_mem[rgbconv_pkg::MAX_WIDTH + col] : '0;
        mid = (in_row >= 1) ? line_mem[col] : '0;
        line_mem[rgbconv_pkg::MAX_WIDTH + col] = mid;
        line_mem[col] = pix;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        early = (in_col == 0);
        // At column zero the output is the last pixel of the previous row.
        if (early)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i][0] = win[i][1];
                t[i][1] = win[i][2];
                t[i][2] = '0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        if (!early) t = win;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (emit)
        begin
            row_end = (out_col + 1 >= w);
            for (int i = 0; i < 3; i++)
            begin
                if (out_col == 0) t[i][0] = '0;
                if (row_end) t[i][2] = '0;
            end
            last = row_end && (out_row + 1 >= h);
            res.blue = filter_channel(t, 0);
            res.green = filter_channel(t, 1);
            res.red = filter_channel(t, 2);
            res.last = last;
            pending_pixels.push_back(res);
            if (last)
            begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end
            else if (row_end)
            begin
                out_col = 0;
                out_row++;
            end
            else
            begin
                out_col++;
            end
        end
    endtask

    task automatic send_pixel(logic m, rgbconv_pkg::chan_t b, rgbconv_pkg::chan_t g,
                              rgbconv_pkg::chan_t r);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= m;
        in_ch.in_blue <= b;
        in_ch.in_green <= g;
        in_ch.in_red <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        convolve_transfer(m, b, g, r);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [rgbconv_pkg::CFG_IDX_W-1:0] idx,
                             logic [rgbconv_pkg::ROW_COEF_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            rgbconv_pkg::CFG_IMAGE_WIDTH:  img_width = value[rgbconv_pkg::WIDTH_W-1:0];
            rgbconv_pkg::CFG_IMAGE_HEIGHT: img_height = value[rgbconv_pkg::HEIGHT_W-1:0];
            rgbconv_pkg::CFG_COEF_TOP:     kernel_rows[0] = value;
            rgbconv_pkg::CFG_COEF_MID:     kernel_rows[1] = value;
            rgbconv_pkg::CFG_COEF_BOT:     kernel_rows[2] = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic rgbconv_pkg::chan_t rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [rgbconv_pkg::TAP_W-1:0] rand_tap();
        case ($urandom_range(0, 5))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'($urandom_range(0, (1 << rgbconv_pkg::TAP_W) - 1));
            3: return 18'(-$signed($urandom_range(0, 600)));
            default: return 18'($urandom_range(0, 500));
        endcase
    endfunction

    task automatic random_kernel();
        write_reg(rgbconv_pkg::CFG_COEF_TOP, {rand_tap(), rand_tap(), rand_tap()});
        write_reg(rgbconv_pkg::CFG_COEF_MID, {rand_tap(), rand_tap(), rand_tap()});
        write_reg(rgbconv_pkg::CFG_COEF_BOT, {rand_tap(), rand_tap(), rand_tap()});
    endtask

    // With noise set, some image pixels become drain ticks and some tail ticks carry pixels.
    task automatic send_frame(logic noise);
        int unsigned w;
        int unsigned h;
        w = active_width();
        h = active_height();
        for (int unsigned i = 0; i < w * h; i++)
            send_pixel(noise && $urandom_range(0, 15) == 0, rand_chan(), rand_chan(),
                       rand_chan());
        for (int unsigned i = 0; i <= w; i++)
            send_pixel(noise ? 1'($urandom_range(0, 1)) : 1'b1, rand_chan(), rand_chan(),
                       rand_chan());
        frames_sent++;
        wait_idle();
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= (cycle_count % 8 < 5);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("Output transfer with no pixel expected.");
                error_count++;
            end
            else
            begin
                out_pixel_t e;
                e = pending_pixels.pop_front();
                check_field("out_blue", 32'(e.blue), 32'(out_ch.out_blue));
                check_field("out_green", 32'(e.green), 32'(out_ch.out_green));
                check_field("out_red", 32'(e.red), 32'(out_ch.out_red));
                check_field("last_of_frame", 32'(e.last), 32'(out_ch.last_of_frame));
                pixels_checked++;
            end
        end
    end

    task automatic test_directed();
        write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH, 54'd3);
        write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, 54'd3);
        write_reg(rgbconv_pkg::CFG_COEF_TOP, {18'h20000, 18'd1024, 18'h1ffff});
        write_reg(rgbconv_pkg::CFG_COEF_MID, {18'd512, 18'd1024, 18'd512});
        write_reg(rgbconv_pkg::CFG_COEF_BOT, {18'h3fc00, 18'd2048, 18'd0});
        send_pixel(1'b0, 8'hff, 8'h00, 8'hff);
        send_pixel(1'b0, 8'h00, 8'hff, 8'h00);
        send_pixel(1'b1, 8'h55, 8'haa, 8'h55);
        send_pixel(1'b0, 8'h01, 8'h02, 8'h80);
        send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
        send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 8'h7f, 8'h80, 8'hfe);
        send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 8'hff, 8'h00, 8'h00);
        send_pixel(1'b0, 8'h12, 8'h34, 8'h56);
        send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 8'h9a, 8'hbc, 8'hde);
        send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
        frames_sent++;
        wait_idle();
        // Half-step taps place the sums on exact ties for round-to-even.
        write_reg(rgbconv_pkg::CFG_COEF_TOP, 54'd0);
        write_reg(rgbconv_pkg::CFG_COEF_MID, {18'd0, 18'd512, 18'd0});
        write_reg(rgbconv_pkg::CFG_COEF_BOT, 54'd0);
        write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH, 54'd1);
        write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, 54'd1);
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    task automatic test_geometry_extremes();
        random_kernel();
        write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH, 54'd0);
        write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, 54'd0);
        send_frame(1'b1);
        write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH, 54'd1);
        write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, 54'd7);
        send_frame(1'b0);
        write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH, 54'd12);
        write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, 54'd1);
        send_frame(1'b1);
        write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH, 54'd2);
        write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, 54'd2);
        send_frame(1'b0);
    endtask

    task automatic test_random_frames();
        while (items_sent < 1800)
        begin
            write_reg(rgbconv_pkg::CFG_IMAGE_WIDTH,
                      {11'($urandom), 32'($urandom), 11'($urandom_range(1, 12))});
            write_reg(rgbconv_pkg::CFG_IMAGE_HEIGHT, {41'd0, 13'($urandom_range(1, 10))});
            random_kernel();
            send_frame($urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.in_blue = '0;
        in_ch.in_green = '0;
        in_ch.in_red = '0;
        out_ch.ready = 1'b0;
        error_count = 0;
        pixels_checked = 0;
        frames_sent = 0;
        items_sent = 0;
        burst_left = 0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        img_width = 640;
        img_height = 480;
        kernel_rows[0] = '0;
        kernel_rows[1] = 54'd262144;
        kernel_rows[2] = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_geometry_extremes();
        test_random_frames();
        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d input transfers over %0d frames; checked %0d output pixels.",
                 items_sent, frames_sent, pixels_checked);
        if (error_count == 0)
            $display("rgb_2d_convolution_zero_pad_top test passed");
        else
            $display("rgb_2d_convolution_zero_pad_top test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("rgb_2d_convolution_zero_pad_top test failed");
        $finish;
    end

endmodule
